// ===== hw/rtl/wcse_pkg.sv =====
// ----------------------------------------------------------------------------
// wcse_pkg
// shared types, constants and helpers of the channel symbol encoder
// ----------------------------------------------------------------------------
package wcse_pkg;

    localparam int SYMBOL_COUNT = 162;
    localparam int MSG_BITS     = 50;
    localparam int CALL_BITS    = 28;
    localparam int LOC_BITS     = 22;
    localparam int GROUP_COUNT  = (SYMBOL_COUNT + 3) / 4;
    localparam int BANK_COUNT   = 2;
    localparam int RAM_DEPTH    = BANK_COUNT * SYMBOL_COUNT;
    localparam int RAM_AW       = $clog2(RAM_DEPTH);
    localparam int POS_W        = 8;
    localparam int GROUP_W      = 6;

    localparam logic [POS_W-1:0]   SYMBOL_LIMIT = POS_W'(SYMBOL_COUNT);
    localparam logic [POS_W-1:0]   STEP_LAST    = 8'd254;
    localparam logic [GROUP_W-1:0] GROUP_LAST   = GROUP_W'(GROUP_COUNT - 1);
    localparam logic [RAM_AW-1:0]  BANK1_BASE   = RAM_AW'(SYMBOL_COUNT);

    localparam logic [31:0] POLY_A = 32'hF2D05351;
    localparam logic [31:0] POLY_B = 32'hE4613C47;

    // sync vector, bit 0 is the sync of the earliest symbol
    localparam logic [0:167] SYNC_VEC =
        168'hc08e25e02502cd1a1aa92c6a2093b34705301ac600;

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_RUN  = 2'b10
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_READ = 4'b0010,
        B_LAST = 4'b0100,
        B_SEND = 4'b1000
    } back_state_t;

    // fill status of the two banks, front to back
    typedef struct packed {
        logic [BANK_COUNT-1:0] full;
    } bank_status_t;

    // bank handed back once all its bytes are sent
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_release_t;

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int b = 0; b < 8; b++) begin
            r[b] = v[7-b];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/wspr_channel_symbol_encoder.sv =====
// ----------------------------------------------------------------------------
// wspr_channel_symbol_encoder
// k=32 rate 1/2 coder, bit-reversal interleaver and sync merge for beacons
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one item is one 50-bit message, callsign code in the low
//   28 bits of s_tdata and the locator/power code above it
//   m_ channel: 41 items per message, each a byte of four 2-bit symbols
//   (earliest in bits 7:6) plus its position in the frame; m_tlast marks
//   the final byte, whose low nibble is zero padding
//   the front stage codes and scatters a message into one of two banks
//   of a 324 x 1 memory; the back stage reads a full bank one symbol per
//   cycle while it gathers a byte, and holds each byte until the receiver
//   takes it
//   the two banks form a two-message queue, so a new message is taken
//   while the previous frame is still being sent; when the receiver does
//   not stall, the sustained message rate is set by the accept cycle plus
//   the interleaver index sweep
//   reset empties both banks and idles both stages; memory contents need
//   no clearing since every entry is written before it is read
//   a stalled receiver holds the current byte; the front takes no new
//   message while it codes one, and stalls once both banks are full
// ----------------------------------------------------------------------------
module wspr_channel_symbol_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // callsign_code, location_power_code, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // symbol_group, group_index, zero pad
    output logic        m_tlast
);

    wcse_pkg::bank_status_t          status;
    wcse_pkg::bank_release_t         release_bank;
    logic                            wr_en;
    logic [wcse_pkg::RAM_AW-1:0]     wr_addr;
    logic                            wr_data;
    logic [wcse_pkg::RAM_AW-1:0]     rd_addr;
    logic                            rd_data;
    logic [7:0]                      symbol_group;
    logic [wcse_pkg::GROUP_W-1:0]    group_index;
    logic [wcse_pkg::MSG_BITS-1:0]   msg;

    // callsign goes out first, so it takes the top of the message word
    assign msg = {s_tdata[wcse_pkg::CALL_BITS-1:0],
                  s_tdata[wcse_pkg::CALL_BITS +: wcse_pkg::LOC_BITS]};

    wcse_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .msg_in     (msg),
        .release_in (release_bank),
        .status_out (status),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    // two banks of interleaved coded bits
    wcse_ram #(
        .WIDTH (1),
        .DEPTH (wcse_pkg::RAM_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    wcse_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .status_in    (status),
        .release_out  (release_bank),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .symbol_group (symbol_group),
        .group_index  (group_index),
        .m_tlast      (m_tlast)
    );

    assign m_tdata = {2'b00, group_index, symbol_group};

endmodule

// ===== hw/rtl/wcse_ram.sv =====
// ----------------------------------------------------------------------------
// wcse_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module wcse_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 324,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/wcse_front.sv =====
// ----------------------------------------------------------------------------
// wcse_front
// takes a message, runs the convolutional coder and scatters the coded bits
// ----------------------------------------------------------------------------
module wcse_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [wcse_pkg::MSG_BITS-1:0] msg_in,
    input  wcse_pkg::bank_release_t       release_in,
    output wcse_pkg::bank_status_t        status_out,
    output logic                          wr_en,
    output logic [wcse_pkg::RAM_AW-1:0]   wr_addr,
    output logic                          wr_data
);

    wcse_pkg::front_state_t              state_reg, state_next;
    logic [wcse_pkg::BANK_COUNT-1:0]     full_reg, full_next;
    logic                                bank_reg, bank_next;
    logic [wcse_pkg::POS_W-1:0]          step_reg, step_next;
    logic                                odd_reg, odd_next;
    logic [31:0]                         shift_reg, shift_next;
    logic [wcse_pkg::MSG_BITS-1:0]       msg_reg, msg_next;

    logic [7:0]                          rev;
    logic                                take;
    logic [31:0]                         shifted;
    logic                                coded;
    logic                                accept;

    assign s_tready = (state_reg == wcse_pkg::F_IDLE) && !full_reg[bank_reg];
    assign accept   = s_tvalid && s_tready;

    assign rev     = wcse_pkg::reverse8(step_reg);
    assign take    = (state_reg == wcse_pkg::F_RUN) && (rev < wcse_pkg::SYMBOL_LIMIT);
    assign shifted = {shift_reg[30:0], msg_reg[wcse_pkg::MSG_BITS-1]};
    // even positions shift in a new bit, odd ones reuse the register
    assign coded   = odd_reg ? ^(shift_reg & wcse_pkg::POLY_B)
                             : ^(shifted & wcse_pkg::POLY_A);

    assign wr_en   = take;
    assign wr_data = coded;
    assign wr_addr = (bank_reg ? wcse_pkg::BANK1_BASE : '0) + {1'b0, rev};

    assign status_out.full = full_reg;

    always_comb begin
        state_next = state_reg;
        full_next  = full_reg;
        bank_next  = bank_reg;
        step_next  = step_reg;
        odd_next   = odd_reg;
        shift_next = shift_reg;
        msg_next   = msg_reg;
        if (release_in.valid) begin
            full_next[release_in.bank] = 1'b0;
        end
        case (state_reg)
            wcse_pkg::F_IDLE: begin
                if (accept) begin
                    msg_next   = msg_in;
                    shift_next = '0;
                    step_next  = '0;
                    odd_next   = 1'b0;
                    state_next = wcse_pkg::F_RUN;
                end
            end
            wcse_pkg::F_RUN: begin
                step_next = step_reg + 1'b1;
                if (take) begin
                    odd_next = !odd_reg;
                    if (!odd_reg) begin
                        shift_next = shifted;
                        msg_next   = {msg_reg[wcse_pkg::MSG_BITS-2:0], 1'b0};
                    end
                end
                if (step_reg == wcse_pkg::STEP_LAST) begin
                    full_next[bank_reg] = 1'b1;
                    bank_next           = !bank_reg;
                    state_next          = wcse_pkg::F_IDLE;
                end
            end
            default: begin
                state_next = wcse_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wcse_pkg::F_IDLE;
            full_reg  <= '0;
            bank_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            full_reg  <= full_next;
            bank_reg  <= bank_next;
        end
        step_reg  <= step_next;
        odd_reg   <= odd_next;
        shift_reg <= shift_next;
        msg_reg   <= msg_next;
    end

endmodule

// ===== hw/rtl/wcse_back.sv =====
// ----------------------------------------------------------------------------
// wcse_back
// reads a filled bank, merges sync bits and sends the symbol bytes
// ----------------------------------------------------------------------------
module wcse_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  wcse_pkg::bank_status_t         status_in,
    output wcse_pkg::bank_release_t        release_out,
    output logic [wcse_pkg::RAM_AW-1:0]    rd_addr,
    input  logic                           rd_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     symbol_group,
    output logic [wcse_pkg::GROUP_W-1:0]   group_index,
    output logic                           m_tlast
);

    wcse_pkg::back_state_t               state_reg, state_next;
    logic                                bank_reg, bank_next;
    logic [wcse_pkg::POS_W-1:0]          pos_reg, pos_next;
    logic [wcse_pkg::POS_W-1:0]          pos_d_reg;
    logic                                rdv_reg, rdv_next;
    logic [1:0]                          cnt_reg, cnt_next;
    logic [wcse_pkg::GROUP_W-1:0]        group_reg, group_next;
    logic [7:0]                          byte_reg, byte_next;
    logic [1:0]                          sym;
    logic                                is_last;

    // symbols past the end of the frame are zero padding
    assign sym = (pos_d_reg < wcse_pkg::SYMBOL_LIMIT)
                 ? {rd_data, wcse_pkg::SYNC_VEC[pos_d_reg]} : 2'b00;

    assign rd_addr = (bank_reg ? wcse_pkg::BANK1_BASE : '0)
                   + ((pos_reg < wcse_pkg::SYMBOL_LIMIT) ? {1'b0, pos_reg} : '0);

    assign is_last      = (group_reg == wcse_pkg::GROUP_LAST);
    assign m_tvalid     = (state_reg == wcse_pkg::B_SEND);
    assign symbol_group = byte_reg;
    assign group_index  = group_reg;
    assign m_tlast      = is_last;

    always_comb begin
        state_next        = state_reg;
        bank_next         = bank_reg;
        pos_next          = pos_reg;
        rdv_next          = 1'b0;
        cnt_next          = cnt_reg;
        group_next        = group_reg;
        byte_next         = byte_reg;
        release_out.valid = 1'b0;
        release_out.bank  = bank_reg;
        if (rdv_reg) begin
            byte_next = {byte_reg[5:0], sym};
        end
        case (state_reg)
            wcse_pkg::B_IDLE: begin
                pos_next   = '0;
                group_next = '0;
                cnt_next   = '0;
                if (status_in.full[bank_reg]) begin
                    state_next = wcse_pkg::B_READ;
                end
            end
            wcse_pkg::B_READ: begin
                rdv_next = 1'b1;
                pos_next = pos_reg + 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 2'd3) begin
                    state_next = wcse_pkg::B_LAST;
                end
            end
            wcse_pkg::B_LAST: begin
                state_next = wcse_pkg::B_SEND;
            end
            wcse_pkg::B_SEND: begin
                if (m_tready) begin
                    if (is_last) begin
                        release_out.valid = 1'b1;
                        bank_next         = !bank_reg;
                        state_next        = wcse_pkg::B_IDLE;
                    end else begin
                        group_next = group_reg + 1'b1;
                        state_next = wcse_pkg::B_READ;
                    end
                end
            end
            default: begin
                state_next = wcse_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wcse_pkg::B_IDLE;
            bank_reg  <= 1'b0;
            rdv_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            rdv_reg   <= rdv_next;
        end
        pos_reg   <= pos_next;
        pos_d_reg <= pos_reg;
        cnt_reg   <= cnt_next;
        group_reg <= group_next;
        byte_reg  <= byte_next;
    end

endmodule

// ===== hw/rtl/wcse_checker.sv =====
// ----------------------------------------------------------------------------
// wcse_checker
// port-level checks of the symbol byte stream
// ----------------------------------------------------------------------------
module wcse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // a taken message closes the input as its coding starts
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a message was taken");

    // stalled byte holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output byte changed");

    // tlast sits exactly on the final position
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[13:8] == 6'd40)))
        else $error("tlast does not match final position");

    // final byte carries padding in its low nibble, and the top pad bits are zero
    a_last_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata[3:0] == 4'd0) && (m_tdata[15:14] == 2'd0))
        else $error("final byte padding not zero");

    // first byte carries sync pattern 1,1,0,0
    a_first_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[13:8] == 6'd0) |->
            m_tdata[6] && m_tdata[4] && !m_tdata[2] && !m_tdata[0])
        else $error("first byte sync bits wrong");

endmodule

bind wspr_channel_symbol_encoder wcse_checker u_wcse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== bench/tb_wspr_channel_symbol_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wspr_channel_symbol_encoder
// self-checking bench for the beacon channel symbol encoder
// ----------------------------------------------------------------------------
// every accepted message is coded, interleaved and merged with the sync
// vector by a behavioural encoder in the bench, giving 41 expected bytes;
// each byte leaving the block is checked against the oldest expectation.
// a short directed set covers the field extremes and the ignored pad bits,
// then random messages follow with random gaps on the sender, random
// back-pressure on the receiver and one long receiver hold-off that fills
// both banks and stalls the input
// ----------------------------------------------------------------------------
module tb_wspr_channel_symbol_encoder;

    localparam int TAIL_BITS    = 31;
    localparam int RANDOM_MSGS  = 408;
    // extra run after the last expected byte, so that stray output
    // bytes after the last frame would still be caught
    localparam int DRAIN_CYCLES = 400;
    // longest quiet stretch of a correct run is the long receiver hold-off;
    // a long sender gap plus first-byte latency stays well below it
    localparam int IDLE_LIMIT   = 20000;
    localparam int HOLD_CYCLES  = 3000;

    // one output byte as the block should send it
    typedef struct {
        logic [7:0]                   symbols;
        logic [wcse_pkg::GROUP_W-1:0] position;
        logic                         last;
    } symbol_byte_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;   // callsign_code, location_power_code, zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // symbol_group, group_index, zero pad
    logic        m_tlast;

    logic [55:0]  message_q[$];     // messages still to be offered
    symbol_byte_t frame_bytes_q[$]; // bytes predicted but not yet received

    int  mismatches   = 0;
    int  bytes_seen   = 0;
    int  idle_cycles  = 0;
    bit  msg_taken    = 1'b0;
    int  send_gap     = 0;
    int  sent_count   = 0;
    bit  send_calm    = 1'b0;
    int  hold_count   = 0;
    bit  recv_calm    = 1'b0;
    int  recv_cycles  = 0;
    bit  hold_done    = 1'b0;

    wspr_channel_symbol_encoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // behavioural encoder: conv code, bit-reversal scatter, sync merge
    function automatic void encode_frame(
        input logic [wcse_pkg::CALL_BITS-1:0] callsign,
        input logic [wcse_pkg::LOC_BITS-1:0]  locator);
        logic [wcse_pkg::MSG_BITS-1:0]     msg;
        logic [31:0]                       coder;
        logic [wcse_pkg::SYMBOL_COUNT-1:0] coded;
        logic [wcse_pkg::SYMBOL_COUNT-1:0] scattered;
        logic [7:0]                        idx;
        logic [7:0]                        rev;
        logic [1:0]                        sym;
        int                                taken;
        int                                p;
        symbol_byte_t                      b;
        msg   = {callsign, locator};
        coder = '0;
        for (int i = 0; i < wcse_pkg::MSG_BITS + TAIL_BITS; i++) begin
            coder = {coder[30:0],
                     (i < wcse_pkg::MSG_BITS) ? msg[wcse_pkg::MSG_BITS-1-i] : 1'b0};
            coded[2*i]   = ^(coder & wcse_pkg::POLY_A);
            coded[2*i+1] = ^(coder & wcse_pkg::POLY_B);
        end
        // walk the 8-bit index space, keeping reversed indices in range
        taken = 0;
        for (int i = 0; i < 255 && taken < wcse_pkg::SYMBOL_COUNT; i++) begin
            idx = 8'(i);
            for (int k = 0; k < 8; k++) begin
                rev[k] = idx[7-k];
            end
            if (rev < wcse_pkg::SYMBOL_COUNT) begin
                scattered[rev] = coded[taken];
                taken++;
            end
        end
        for (int g = 0; g < wcse_pkg::GROUP_COUNT; g++) begin
            b.symbols = '0;
            for (int s = 0; s < 4; s++) begin
                p   = 4 * g + s;
                sym = (p < wcse_pkg::SYMBOL_COUNT)
                      ? {scattered[p], wcse_pkg::SYNC_VEC[p]} : 2'b00;
                b.symbols = {b.symbols[5:0], sym};
            end
            b.position = wcse_pkg::GROUP_W'(g);
            b.last     = (g == wcse_pkg::GROUP_COUNT - 1);
            frame_bytes_q.push_back(b);
        end
    endfunction

    // mostly back-to-back or short gaps, now and then a long one
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(99);
        if (calm || r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 300);
    endfunction

    function automatic logic [55:0] pack_message(
        input logic [wcse_pkg::CALL_BITS-1:0] callsign,
        input logic [wcse_pkg::LOC_BITS-1:0]  locator,
        input logic [5:0]                     pad);
        return {pad, locator, callsign};
    endfunction

    // sender: a new item goes out at a falling edge once the last one was taken and its gap has run out
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !msg_taken) begin
            // item still on offer, hold it
        end else if (send_gap > 0) begin
            send_gap--;
            s_tvalid <= 1'b0;
        end else if (message_q.size() > 0) begin
            s_tdata  <= message_q.pop_front();
            s_tvalid <= 1'b1;
            sent_count++;
            if (sent_count % 16 == 0) begin
                send_calm = ($urandom_range(3) == 0);
            end
            send_gap = pick_gap(send_calm);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver back-pressure, with one long hold-off once traffic is flowing
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            recv_cycles++;
            if (recv_cycles % 500 == 0) begin
                recv_calm = ($urandom_range(3) == 0);
            end
            if (!hold_done && bytes_seen >= 60) begin
                // both banks fill up while this lasts, so s_tready must drop
                hold_done  = 1'b1;
                hold_count = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (hold_count > 0) begin
                hold_count--;
                m_tready <= 1'b0;
            end else if (recv_calm || $urandom_range(99) < 70) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                hold_count = ($urandom_range(19) == 0) ? $urandom_range(20, 200)
                                                       : $urandom_range(0, 3);
            end
        end
    end

    // sampling at the rising edge: prediction, checking, quiet-cycle count
    always @(posedge aclk) begin
        symbol_byte_t want;
        msg_taken = aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (msg_taken) begin
                encode_frame(s_tdata[wcse_pkg::CALL_BITS-1:0],
                             s_tdata[wcse_pkg::CALL_BITS +: wcse_pkg::LOC_BITS]);
            end
            if (m_tvalid && m_tready) begin
                bytes_seen++;
                if (frame_bytes_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: expected no item, actual symbols=%h index=%0d last=%b",
                             $time, m_tdata[7:0], m_tdata[13:8], m_tlast);
                end else begin
                    want = frame_bytes_q.pop_front();
                    if (m_tdata[7:0] !== want.symbols) begin
                        mismatches++;
                        $display("%0t: symbol_group expected %h actual %h",
                                 $time, want.symbols, m_tdata[7:0]);
                    end
                    if (m_tdata[13:8] !== want.position) begin
                        mismatches++;
                        $display("%0t: group_index expected %0d actual %0d",
                                 $time, want.position, m_tdata[13:8]);
                    end
                    if (m_tlast !== want.last) begin
                        mismatches++;
                        $display("%0t: last expected %b actual %b",
                                 $time, want.last, m_tlast);
                    end
                end
            end
            if (msg_taken || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    initial begin
        logic [wcse_pkg::CALL_BITS-1:0] callsign;
        logic [wcse_pkg::LOC_BITS-1:0]  locator;
        logic [5:0]                     pad;
        int                             r;

        // directed: field extremes, alternating and single-bit patterns,
        // and non-zero pad bits above the fields, which must be ignored
        message_q.push_back(pack_message('0, '0, 6'h00));
        message_q.push_back(pack_message('1, '1, 6'h00));
        message_q.push_back(pack_message('1, '0, 6'h00));
        message_q.push_back(pack_message('0, '1, 6'h00));
        message_q.push_back(pack_message(28'hAAAAAAA, 22'h2AAAAA, 6'h00));
        message_q.push_back(pack_message(28'h5555555, 22'h155555, 6'h00));
        message_q.push_back(pack_message(28'h0000001, 22'h000000, 6'h00));
        message_q.push_back(pack_message(28'h8000000, 22'h000000, 6'h00));
        message_q.push_back(pack_message(28'h0000000, 22'h000001, 6'h00));
        message_q.push_back(pack_message(28'h0000000, 22'h200000, 6'h00));
        message_q.push_back(pack_message(28'h0123456, 22'h0ABCDE, 6'h00));
        message_q.push_back(pack_message('0, '0, 6'h3F));
        message_q.push_back(pack_message('1, '1, 6'h15));

        for (int n = 0; n < RANDOM_MSGS; n++) begin
            r = $urandom_range(99);
            callsign = wcse_pkg::CALL_BITS'($urandom);
            locator  = wcse_pkg::LOC_BITS'($urandom);
            if (r < 8) begin
                locator = ($urandom_range(1) == 0) ? '0 : '1;
            end else if (r < 16) begin
                // sparse message: one set bit somewhere in the 50
                callsign = '0;
                locator  = '0;
                r = $urandom_range(wcse_pkg::MSG_BITS - 1);
                if (r < wcse_pkg::LOC_BITS) begin
                    locator[r] = 1'b1;
                end else begin
                    callsign[r - wcse_pkg::LOC_BITS] = 1'b1;
                end
            end
            pad = ($urandom_range(9) == 0) ? 6'($urandom) : 6'h00;
            message_q.push_back(pack_message(callsign, locator, pad));
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // run until every message is in and every byte is back
        while (!(message_q.size() == 0 && !s_tvalid && frame_bytes_q.size() == 0)
               && idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
        end
        // stray bytes after the last frame would show up here
        if (idle_cycles < IDLE_LIMIT) begin
            repeat (DRAIN_CYCLES) @(posedge aclk);
        end

        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
        end else if (mismatches == 0 && frame_bytes_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
